>>> hw/rtl/acs_pkg.sv
// shared types, constants and shaping functions of the contextual shaper
package acs_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // one letter ready for shaping, with its joining context
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            prev_joins;
    logic            next_joins;
    logic            last;
  } job_t;

  // what the front pushes into the queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    job_t       first;
    job_t       second;
  } push_t;

  function automatic logic in_letter_range(input logic [CP_W-1:0] c);
    return (c > 21'h600 && c < 21'h660) || (c > 21'h669 && c < 21'h76E);
  endfunction

  function automatic logic joins_forward(input logic [CP_W-1:0] c);
    logic res;
    res = in_letter_range(c);
    if (c == 21'h627 || c == 21'h648 || c == 21'h698) res = 1'b0;
    if (c > 21'h62E && c < 21'h633) res = 1'b0;
    if (c > 21'h620 && c < 21'h626) res = 1'b0;
    return res;
  endfunction

  // medial form of a four-form letter, zero when not one
  function automatic logic [15:0] medial_base(input logic [CP_W-1:0] c);
    logic [15:0] m;
    case (c)
      21'h626: m = 16'hFE8C;
      21'h628: m = 16'hFE92;
      21'h62A: m = 16'hFE98;
      21'h62B: m = 16'hFE9C;
      21'h62C: m = 16'hFEA0;
      21'h62D: m = 16'hFEA4;
      21'h62E: m = 16'hFEA8;
      21'h633: m = 16'hFEB4;
      21'h634: m = 16'hFEB8;
      21'h635: m = 16'hFEBC;
      21'h636: m = 16'hFEC0;
      21'h639: m = 16'hFECC;
      21'h63A: m = 16'hFED0;
      21'h641: m = 16'hFED4;
      21'h642: m = 16'hFED8;
      21'h644: m = 16'hFEE0;
      21'h645: m = 16'hFEE4;
      21'h646: m = 16'hFEE8;
      21'h647: m = 16'hFEEC;
      21'h67E: m = 16'hFB59;
      21'h686: m = 16'hFB7D;
      21'h6A9: m = 16'hFB91;
      21'h6AF: m = 16'hFB95;
      default: m = 16'h0000;
    endcase
    return m;
  endfunction

  // joined form of a two-form letter, zero when not one
  function automatic logic [15:0] joined_form(input logic [CP_W-1:0] c);
    logic [15:0] j;
    case (c)
      21'h627: j = 16'hFE8E;
      21'h62F: j = 16'hFEAA;
      21'h630: j = 16'hFEAC;
      21'h631: j = 16'hFEAE;
      21'h632: j = 16'hFEB0;
      21'h637: j = 16'hFEC4;
      21'h638: j = 16'hFEC8;
      21'h648: j = 16'hFEEE;
      21'h698: j = 16'hFB8B;
      default: j = 16'h0000;
    endcase
    return j;
  endfunction

  function automatic logic [CP_W-1:0] shape(input logic [CP_W-1:0] c,
                                            input logic bp, input logic bn);
    logic [15:0]     m;
    logic [15:0]     j;
    logic [15:0]     f;
    logic [CP_W-1:0] res;
    m = medial_base(c);
    j = joined_form(c);
    res = c;
    if (m != 16'h0000) begin
      if (bp && bn) f = m;
      else if (bn) f = m - 16'd1;
      else if (bp) f = m - 16'd2;
      else f = m - 16'd3;
      res = {5'b0, f};
    end else if (j != 16'h0000) begin
      f = bp ? j : j - 16'd1;
      res = {5'b0, f};
    end else if (c == 21'h64A || c == 21'h6CC) begin
      if (bp && bn) f = 16'hFEF4;
      else if (bp) f = 16'hFEF0;
      else if (bn) f = 16'hFEF3;
      else f = 16'hFEEF;
      res = {5'b0, f};
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/acs_front.sv
// front end: holds the pending letter and works out joining context
module acs_front
  import acs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [CP_W-1:0] code_point,
  input  logic            end_of_string,
  input  logic            room,
  output push_t           push
);

  logic [CP_W-1:0] held_char;
  logic            held_valid;
  logic            before_held_joins;
  logic            accept;
  logic            bp_cur;
  job_t            held_job;
  job_t            cur_job;

  assign in_ready = room;
  assign accept   = in_valid && room;
  assign bp_cur   = held_valid && joins_forward(held_char);

  always_comb begin
    held_job.cp         = held_char;
    held_job.prev_joins = before_held_joins;
    held_job.next_joins = in_letter_range(code_point);
    held_job.last       = 1'b0;
    cur_job.cp          = code_point;
    cur_job.prev_joins  = bp_cur;
    cur_job.next_joins  = 1'b0;
    cur_job.last        = 1'b1;
    push.count  = 2'd0;
    push.first  = held_job;
    push.second = cur_job;
    if (accept) begin
      if (held_valid && end_of_string) begin
        push.count = 2'd2;
      end else if (held_valid) begin
        push.count = 2'd1;
      end else if (end_of_string) begin
        push.count = 2'd1;
        push.first = cur_job;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid        <= 1'b0;
      before_held_joins <= 1'b0;
    end else if (accept) begin
      held_valid        <= !end_of_string;
      before_held_joins <= end_of_string ? 1'b0 : bp_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !end_of_string) begin
      held_char <= code_point;
    end
  end

endmodule

>>> hw/rtl/acs_queue.sv
// short queue between front and back, two pushes and one pop per cycle
module acs_queue
  import acs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  head_valid,
  output job_t  head,
  input  logic  pop
);

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic              do_pop;

  assign do_pop     = pop && head_valid;
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  // room for the worst case of two entries from one transaction
  assign room       = (count <= QCNT_W'(QDEPTH - 2));

  always_comb begin
    count_next = count + QCNT_W'(push.count) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      count  <= count_next;
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

endmodule

>>> hw/rtl/acs_back.sv
// back end: table lookup of the presentation form and output register
module acs_back
  import acs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  job_t            head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] shaped_char,
  output logic            last_of_string
);

  logic take;

  assign take = !out_valid || out_ready;
  assign pop  = take && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shaped_char    <= shape(head.cp, head.prev_joins, head.next_joins);
      last_of_string <= head.last;
    end
  end

endmodule

>>> hw/rtl/arabic_contextual_shaper_unit.sv
// top level of the arabic contextual shaper
// Replaces each Arabic/Persian letter of a code point stream by its isolated,
// final, initial or medial presentation form; other code points pass through.
// Takes one code point per clock while the queue has room. A code point is held until the next
// code point arrives, so its result leaves after that next transaction; the code point
// marked end_of_string gives two results when one is held (the held one and itself, the
// latter with last_of_string set), which the single output register drains
// one at a time. A four-entry queue between the classifying front and the
// lookup back absorbs that and lets either side stall; input stalls only when
// the queue holds more than two entries. The result of the completing code point
// passes through the queue and then the output register before it is valid.
module arabic_contextual_shaper_unit
  import acs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [CP_W-1:0] code_point,
  input  logic            end_of_string,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] shaped_char,
  output logic            last_of_string
);

  push_t push;
  logic  room;
  logic  head_valid;
  job_t  head;
  logic  pop;

  acs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .code_point    (code_point),
    .end_of_string (end_of_string),
    .room          (room),
    .push          (push)
  );

  acs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  acs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .shaped_char    (shaped_char),
    .last_of_string (last_of_string)
  );

endmodule

>>> tb/shaper_checker.sv
// scoreboard for the contextual shaper: predicts shaped glyphs and checks the output channel
module shaper_checker
  import acs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic [CP_W-1:0] code_point,
  input  logic            end_of_string,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic [CP_W-1:0] shaped_char,
  input  logic            last_of_string,
  output int              fail_count,
  output int              glyphs_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CP_W-1:0] YEH_ARABIC = 21'h64A;
  localparam logic [CP_W-1:0] YEH_FARSI  = 21'h6CC;

  typedef struct packed {
    logic [CP_W-1:0] glyph;
    logic            last;
  } glyph_t;

  glyph_t          expected_glyphs[$];
  logic [CP_W-1:0] waiting_char;
  bit              waiting_valid;
  bit              waiting_after_joiner;
  int              mismatches;

  function automatic bit is_arabic_letter(input logic [CP_W-1:0] c);
    return (c >= 21'h601 && c <= 21'h65F) || (c >= 21'h66A && c <= 21'h76D);
  endfunction

  // true for letters that connect to the one after them
  function automatic bit links_to_next(input logic [CP_W-1:0] c);
    if (!is_arabic_letter(c)) return 1'b0;
    if (c >= 21'h621 && c <= 21'h625) return 1'b0;
    if (c >= 21'h62F && c <= 21'h632) return 1'b0;
    if (c == 21'h627 || c == 21'h648 || c == 21'h698) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [CP_W-1:0] shaped_form(input logic [CP_W-1:0] c,
                                                  input bit join_prev,
                                                  input bit join_next);
    logic [CP_W-1:0] medial;
    logic [CP_W-1:0] linked;
    medial = '0;
    linked = '0;
    case (c)
      21'h626: medial = 21'h0FE8C;
      21'h628: medial = 21'h0FE92;
      21'h62A: medial = 21'h0FE98;
      21'h62B: medial = 21'h0FE9C;
      21'h62C: medial = 21'h0FEA0;
      21'h62D: medial = 21'h0FEA4;
      21'h62E: medial = 21'h0FEA8;
      21'h633: medial = 21'h0FEB4;
      21'h634: medial = 21'h0FEB8;
      21'h635: medial = 21'h0FEBC;
      21'h636: medial = 21'h0FEC0;
      21'h639: medial = 21'h0FECC;
      21'h63A: medial = 21'h0FED0;
      21'h641: medial = 21'h0FED4;
      21'h642: medial = 21'h0FED8;
      21'h644: medial = 21'h0FEE0;
      21'h645: medial = 21'h0FEE4;
      21'h646: medial = 21'h0FEE8;
      21'h647: medial = 21'h0FEEC;
      21'h67E: medial = 21'h0FB59;
      21'h686: medial = 21'h0FB7D;
      21'h6A9: medial = 21'h0FB91;
      21'h6AF: medial = 21'h0FB95;
      default: medial = '0;
    endcase
    case (c)
      21'h627: linked = 21'h0FE8E;
      21'h62F: linked = 21'h0FEAA;
      21'h630: linked = 21'h0FEAC;
      21'h631: linked = 21'h0FEAE;
      21'h632: linked = 21'h0FEB0;
      21'h637: linked = 21'h0FEC4;
      21'h638: linked = 21'h0FEC8;
      21'h648: linked = 21'h0FEEE;
      21'h698: linked = 21'h0FB8B;
      default: linked = '0;
    endcase
    // four-form block is laid out isolated, final, initial, medial
    if (medial != '0) begin
      if (join_prev && join_next) return medial;
      if (join_next) return medial - 21'd1;
      if (join_prev) return medial - 21'd2;
      return medial - 21'd3;
    end
    if (linked != '0) return join_prev ? linked : linked - 21'd1;
    if (c == YEH_ARABIC || c == YEH_FARSI) begin
      if (join_prev && join_next) return 21'h0FEF4;
      if (join_prev) return 21'h0FEF0;
      if (join_next) return 21'h0FEF3;
      return 21'h0FEEF;
    end
    return c;
  endfunction

  task automatic predict_glyphs(input logic [CP_W-1:0] cp, input logic eos);
    bit joiner;
    joiner = 1'b0;
    // a new code point settles the form of the letter held back
    if (waiting_valid) begin
      expected_glyphs.push_back({shaped_form(waiting_char, waiting_after_joiner,
                                             is_arabic_letter(cp)), 1'b0});
      joiner = links_to_next(waiting_char);
    end
    if (eos) begin
      expected_glyphs.push_back({shaped_form(cp, joiner, 1'b0), 1'b1});
      waiting_valid        = 1'b0;
      waiting_after_joiner = 1'b0;
    end else begin
      waiting_char         = cp;
      waiting_valid        = 1'b1;
      waiting_after_joiner = joiner;
    end
  endtask

  always @(posedge clk) begin
    glyph_t want;
    if (rst) begin
      expected_glyphs.delete();
      waiting_valid        = 1'b0;
      waiting_after_joiner = 1'b0;
    end else begin
      if (in_valid && in_ready) predict_glyphs(code_point, end_of_string);
      if (out_valid && out_ready) begin
        if (expected_glyphs.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction, expected none, got shaped_char %h last %b",
                   $time, shaped_char, last_of_string);
        end else begin
          want = expected_glyphs.pop_front();
          if (shaped_char !== want.glyph) begin
            mismatches++;
            $display("%0t: shaped_char expected %h, got %h", $time, want.glyph, shaped_char);
          end
          if (last_of_string !== want.last) begin
            mismatches++;
            $display("%0t: last_of_string expected %b, got %b", $time, want.last,
                     last_of_string);
          end
        end
      end
    end
    fail_count         <= mismatches;
    glyphs_outstanding <= expected_glyphs.size();
  end

endmodule

>>> tb/tb_top.sv
// testbench top of the contextual shaper: stimulus, flow control, watchdog and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import acs_pkg::*;

  localparam int PHASE_ITEMS   = 420;
  localparam int HOLD_CYCLES   = 300;
  localparam int WATCHDOG_IDLE = 5000;

  logic            clk;
  logic            rst            = 1'b1;
  logic            in_valid       = 1'b0;
  logic            in_ready;
  logic [CP_W-1:0] code_point     = '0;
  logic            end_of_string  = 1'b0;
  logic            out_valid;
  logic            out_ready      = 1'b0;
  logic [CP_W-1:0] shaped_char;
  logic            last_of_string;

  int fail_count;
  int glyphs_outstanding;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int phase_items;
  int idle_cycles    = 0;
  bit drain_hold_req = 1'b0;
  bit hold_done      = 1'b0;

  arabic_contextual_shaper_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .code_point    (code_point),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .shaped_char   (shaped_char),
    .last_of_string(last_of_string)
  );

  shaper_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .code_point        (code_point),
    .end_of_string     (end_of_string),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .shaped_char       (shaped_char),
    .last_of_string    (last_of_string),
    .fail_count        (fail_count),
    .glyphs_outstanding(glyphs_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // letters with a shaping rule, plus the hamza group that never joins forward
  function automatic logic [CP_W-1:0] listed_letter(input int idx);
    case (idx)
      0: return 21'h626;   1: return 21'h628;   2: return 21'h62A;   3: return 21'h62B;
      4: return 21'h62C;   5: return 21'h62D;   6: return 21'h62E;   7: return 21'h633;
      8: return 21'h634;   9: return 21'h635;  10: return 21'h636;  11: return 21'h639;
      12: return 21'h63A; 13: return 21'h641;  14: return 21'h642;  15: return 21'h644;
      16: return 21'h645; 17: return 21'h646;  18: return 21'h647;  19: return 21'h67E;
      20: return 21'h686; 21: return 21'h6A9;  22: return 21'h6AF;  23: return 21'h627;
      24: return 21'h62F; 25: return 21'h630;  26: return 21'h631;  27: return 21'h632;
      28: return 21'h637; 29: return 21'h638;  30: return 21'h648;  31: return 21'h698;
      32: return 21'h64A; 33: return 21'h6CC;  34: return 21'h621;  35: return 21'h622;
      36: return 21'h623; 37: return 21'h624;
      default: return 21'h625;
    endcase
  endfunction

  function automatic logic [CP_W-1:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 75) return listed_letter($urandom_range(38));
    if (r < 87) return CP_W'($urandom_range(21'h770, 21'h5FE));
    if (r < 94) return CP_W'($urandom_range(8'h7E, 8'h20));
    return CP_W'($urandom_range(21'h1FFFFF, 0));
  endfunction

  task automatic send_code_point(input logic [CP_W-1:0] cp, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    code_point    <= cp;
    end_of_string <= eos;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_string();
    int              len;
    bit              noisy;
    logic [CP_W-1:0] cp;
    noisy = ($urandom_range(99) < 8);
    len   = ($urandom_range(9) < 7) ? $urandom_range(6, 1) : $urandom_range(20, 7);
    for (int i = 0; i < len; i++) begin
      cp = noisy ? CP_W'($urandom_range(21'h1FFFFF, 0)) : pick_code();
      send_code_point(cp, i == len - 1);
      phase_items++;
    end
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (drain_hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        drain_hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: cycles without any transaction on either channel
  initial begin
    while (idle_cycles < WATCHDOG_IDLE) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // single-letter string, then isolated ye
    send_code_point(21'h628, 1'b1);
    send_code_point(21'h6CC, 1'b1);
    // ye initial, medial, final
    send_code_point(21'h64A, 1'b0); send_code_point(21'h64A, 1'b0);
    send_code_point(21'h6CC, 1'b1);
    // alef breaks the join: isolated alef, initial beh, final alef
    send_code_point(21'h627, 1'b0); send_code_point(21'h628, 1'b0);
    send_code_point(21'h627, 1'b1);
    // edges of the letter ranges and of the code point field
    send_code_point(21'h000000, 1'b0); send_code_point(21'h601, 1'b0);
    send_code_point(21'h600, 1'b0);    send_code_point(21'h65F, 1'b0);
    send_code_point(21'h660, 1'b0);    send_code_point(21'h66A, 1'b0);
    send_code_point(21'h669, 1'b0);    send_code_point(21'h76D, 1'b0);
    send_code_point(21'h76E, 1'b0);    send_code_point(21'h1FFFFF, 1'b1);
    // non-joining letters between joining ones, two-form letters both ways
    send_code_point(21'h644, 1'b0); send_code_point(21'h621, 1'b0);
    send_code_point(21'h698, 1'b0); send_code_point(21'h648, 1'b0);
    send_code_point(21'h62F, 1'b0); send_code_point(21'h632, 1'b0);
    send_code_point(21'h633, 1'b1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        // fill the block while the output is held off
        if (p == 0 && !hold_done && phase_items >= 150) begin
          drain_hold_req = 1'b1;
          hold_done      = 1'b1;
        end
        send_random_string();
      end
    end
    in_valid       <= 1'b0;
    recv_stall_pct = 0;

    do @(posedge clk); while (glyphs_outstanding != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && glyphs_outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
